### design/abf_pkg.sv
// ----------------------------------------------------------------------------
// abf_pkg
// Types and codes used by the alpha-blend frame store and its blend unit.
// ----------------------------------------------------------------------------
package abf_pkg;

  // Command codes carried in the request's opcode field.
  typedef enum logic [1:0] {
    OP_BLEND = 2'd0,
    OP_READ  = 2'd1,
    OP_FILL  = 2'd2,
    OP_MARK  = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [7:0] CFG_SIZE_RESET = 8'd128;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR    = 8'h00;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_DONE
  } abf_state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic        [15:0] rect_width;
    logic        [15:0] rect_height;
    logic        [31:0] color;
    logic               mark_value;
  } in_t;

  typedef struct packed {
    logic [31:0] read_color;
    logic        dirty_mark;
  } out_t;

endpackage

### design/alpha_blend_framebuffer.sv
// ----------------------------------------------------------------------------
// alpha_blend_framebuffer
// A request passes a setup state, then a read and a write for each covered pixel, then
// a result state. A read only fetches its pixel, an opaque colour is written without
// fetching the old pixel; a mark, a no-op or a clipped request skips to the result.
// One request is in work at a time; the next is taken only after the result is raised.
// After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT entries of the store.
// ----------------------------------------------------------------------------
module alpha_blend_framebuffer
  import abf_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Control and payload registers.
  abf_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  in_t               req_r, req_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        col_start_r, col_start_nxt;
  logic [7:0]        col_end_r, col_end_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [7:0]        row_end_r, row_end_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic              dirty_r, dirty_nxt;
  logic [31:0]       rd_color_r, rd_color_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;
  logic [7:0]        fw_r, fh_r;

  // Frame size in use: register values above the maximum act as the maximum.
  logic [7:0] w_eff, h_eff;
  assign w_eff = (int'(fw_r) > MAX_WIDTH)  ? 8'(MAX_WIDTH)  : fw_r;
  assign h_eff = (int'(fh_r) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : fh_r;

  // Clipping of the request to the frame. A single-pixel blend or read is
  // handled as a one-by-one rectangle, which gives exactly the inside test.
  logic               is_fill;
  logic [15:0]        rw_eff, rh_eff;
  logic [15:0]        xs, ys;
  logic signed [17:0] xe_full, ye_full;
  logic [7:0]         xe, ye;
  logic               empty;
  logic [15:0]        row_prod;
  logic [7:0]         alpha;

  assign is_fill = (req_r.opcode == OP_FILL);
  assign rw_eff  = is_fill ? req_r.rect_width  : 16'd1;
  assign rh_eff  = is_fill ? req_r.rect_height : 16'd1;
  assign xs      = req_r.x_coord[15] ? 16'd0 : req_r.x_coord;
  assign ys      = req_r.y_coord[15] ? 16'd0 : req_r.y_coord;
  assign xe_full = {{2{req_r.x_coord[15]}}, req_r.x_coord} + $signed({2'b00, rw_eff});
  assign ye_full = {{2{req_r.y_coord[15]}}, req_r.y_coord} + $signed({2'b00, rh_eff});
  assign xe      = (xe_full > $signed({10'd0, w_eff})) ? w_eff : xe_full[7:0];
  assign ye      = (ye_full > $signed({10'd0, h_eff})) ? h_eff : ye_full[7:0];
  assign empty   = (xs >= {8'd0, w_eff}) || (xe_full <= $signed({2'b00, xs}))
                || (ys >= {8'd0, h_eff}) || (ye_full <= $signed({2'b00, ys}));
  // When the rectangle is not empty its first row lies below 256.
  assign row_prod = ys[7:0] * w_eff;
  assign alpha    = req_r.color[31:24];

  // Pixel address and the walk over the clipped rectangle.
  logic [ADDR_W-1:0] pix_addr;
  logic              last_col, last_row;
  assign pix_addr = row_base_r + ADDR_W'(col_r);
  assign last_col = ({1'b0, col_r} + 9'd1) == {1'b0, col_end_r};
  assign last_row = ({1'b0, row_r} + 9'd1) == {1'b0, row_end_r};

  // Memory and blend unit connections.
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [23:0]       mem_wdata, mem_rdata, blend_rgb;

  abf_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (pix_addr),
    .rdata (mem_rdata)
  );

  abf_blend u_blend (
    .dst_rgb (mem_rdata),
    .color   (req_r.color),
    .new_rgb (blend_rgb)
  );

  // Sequencer: next state and outputs.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    req_nxt       = req_r;
    col_nxt       = col_r;
    col_start_nxt = col_start_r;
    col_end_nxt   = col_end_r;
    row_nxt       = row_r;
    row_end_nxt   = row_end_r;
    row_base_nxt  = row_base_r;
    dirty_nxt     = dirty_r;
    rd_color_nxt  = rd_color_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = pix_addr;
    mem_wdata     = blend_rgb;

    unique case (state_r)
      ST_CLEAR: begin
        // Clearing pass: one entry a cycle, no request taken meanwhile.
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        rd_color_nxt  = '0;
        col_nxt       = xs[7:0];
        col_start_nxt = xs[7:0];
        col_end_nxt   = xe;
        row_nxt       = ys[7:0];
        row_end_nxt   = ye;
        row_base_nxt  = ADDR_W'(row_prod);
        state_nxt     = ST_DONE;
        unique case (req_r.opcode)
          OP_MARK: begin
            dirty_nxt = req_r.mark_value;
          end
          OP_READ: begin
            if (!empty) begin
              state_nxt = ST_PIX_RD;
            end
          end
          OP_BLEND, OP_FILL: begin
            // A visible write marks the frame dirty even when fully clipped.
            if (alpha != ALPHA_CLEAR) begin
              dirty_nxt = 1'b1;
              if (!empty) begin
                state_nxt = ST_PIX_RD;
              end
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_PIX_RD: begin
        if (req_r.opcode != OP_READ && alpha == ALPHA_OPAQUE) begin
          // Opaque colour: no need to fetch the old pixel.
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_PIX_WR;
        end
      end

      ST_PIX_WR: begin
        if (req_r.opcode == OP_READ) begin
          rd_color_nxt = {ALPHA_OPAQUE, mem_rdata};
          state_nxt    = ST_DONE;
        end else begin
          mem_we    = 1'b1;
          state_nxt = ST_PIX_RD;
        end
      end

      ST_DONE: begin
        // The result waits here only while the previous one is still held.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_color = rd_color_r;
          out_data_nxt.dirty_mark = dirty_r;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Step to the next pixel after each write of a fill or blend.
    if (mem_we && (state_r == ST_PIX_RD || state_r == ST_PIX_WR)) begin
      if (last_col) begin
        if (last_row) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt    = ST_PIX_RD;
          row_nxt      = row_r + 8'd1;
          col_nxt      = col_start_r;
          row_base_nxt = row_base_r + ADDR_W'(w_eff);
        end
      end else begin
        state_nxt = ST_PIX_RD;
        col_nxt   = col_r + 8'd1;
      end
    end
  end

  // State and control registers; payload registers take no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      dirty_r     <= 1'b1;
      out_valid_r <= 1'b0;
      fw_r        <= CFG_SIZE_RESET;
      fh_r        <= CFG_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r <= cfg_wdata;
          CFG_FRAME_HEIGHT: fh_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    col_r       <= col_nxt;
    col_start_r <= col_start_nxt;
    col_end_r   <= col_end_nxt;
    row_r       <= row_nxt;
    row_end_r   <= row_end_nxt;
    row_base_r  <= row_base_nxt;
    rd_color_r  <= rd_color_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/abf_store.sv
// ----------------------------------------------------------------------------
// abf_store
// RGB888 pixel memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module abf_store #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [23:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [23:0]       rdata
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/abf_blend.sv
// ----------------------------------------------------------------------------
// abf_blend
// Pixel blend unit: mixes an ARGB colour over a stored RGB pixel.
// ----------------------------------------------------------------------------
module abf_blend
  import abf_pkg::*;
(
  input  logic [23:0] dst_rgb,
  input  logic [31:0] color,
  output logic [23:0] new_rgb
);

  // One channel: c + floor((d - c) * inv / 256), wrapped to eight bits.
  function automatic logic [7:0] blend_chan(input logic [7:0] d, input logic [7:0] c,
                                            input logic [8:0] inv);
    logic signed [8:0]  diff;
    logic signed [18:0] prod;
    logic signed [18:0] quot;
    diff = $signed({1'b0, d}) - $signed({1'b0, c});
    prod = diff * $signed({1'b0, inv});
    quot = prod >>> 8;
    return c + quot[7:0];
  endfunction

  logic [7:0] alpha;
  logic [8:0] inv;

  assign alpha = color[31:24];
  assign inv   = 9'd256 - {1'b0, alpha};

  always_comb begin
    if (alpha == ALPHA_OPAQUE) begin
      new_rgb = color[23:0];
    end else begin
      for (int k = 0; k < 3; k++) begin
        new_rgb[k*8 +: 8] = blend_chan(dst_rgb[k*8 +: 8], color[k*8 +: 8], inv);
      end
    end
  end

endmodule
